// ===== src/kti_pkg.sv =====
// ----------------------------------------------------------------------------
// kti_pkg
// Shared types and constants for the keyframe track interpolator.
// ----------------------------------------------------------------------------
package kti_pkg;

    localparam int MAX_KEYS_DEF = 256;
    localparam int NUM_IDS_DEF  = 32;

    localparam int OP_W      = 2;
    localparam int ROW_W     = 16;
    localparam int ID_W      = 5;
    localparam int VAL_W     = 32;
    localparam int BLEND_W   = 3;
    localparam int TIME_W    = 32;
    localparam int STAT_W    = 3;
    localparam int BPM_W     = 16;
    localparam int RPB_W     = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    // row time arithmetic
    localparam int PROD1_W   = TIME_W + RPB_W;
    localparam int PROD_W    = PROD1_W + BPM_W;
    localparam int RT_W      = 51;
    localparam int DIV_W     = PROD_W;
    localparam int DSR_W     = 16;
    localparam int DIV_CNT_W = 6;

    // divide by 60 as (P >> 2) / 15 through a 0x1111... reciprocal
    localparam int RCP_W     = 120;
    localparam int RCP_SHIFT = 64;

    localparam logic [DIV_CNT_W-1:0] ITERS_FRAC    = DIV_CNT_W'(32);
    localparam logic [17:0]          SMOOTH_K      = 18'd196608;

    localparam logic [BPM_W-1:0] BPM_RESET = BPM_W'(120);
    localparam logic [RPB_W-1:0] RPB_RESET = RPB_W'(8);

    localparam logic [CFG_IDX_W-1:0] CFG_BPM = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RPB = 1'b1;

    localparam logic [BLEND_W-1:0] BL_STEP   = 3'd0;
    localparam logic [BLEND_W-1:0] BL_LINEAR = 3'd1;
    localparam logic [BLEND_W-1:0] BL_SMOOTH = 3'd2;
    localparam logic [BLEND_W-1:0] BL_RAMP   = 3'd3;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_INDEX = 2'd2,
        OP_EVAL  = 2'd3
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_VALID     = 3'd0,
        ST_INACTIVE  = 3'd1,
        ST_BAD_BLEND = 3'd2,
        ST_FULL      = 3'd3,
        ST_DONE      = 3'd4
    } status_t;

    typedef struct packed {
        opcode_t              op;
        logic [ROW_W-1:0]     row;
        logic [ID_W-1:0]      id;
        logic                 id_ok;
        logic [VAL_W-1:0]     value;
        logic [BLEND_W-1:0]   blend;
        logic [TIME_W-1:0]    qtime;
    } cmd_t;

    typedef struct packed {
        logic [ROW_W-1:0]     row;
        logic [ID_W-1:0]      id;
        logic [VAL_W-1:0]     value;
        logic [BLEND_W-1:0]   blend;
    } key_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] iters;
    } div_ctl_t;

endpackage

// ===== src/kti_if.sv =====
// ----------------------------------------------------------------------------
// kti_in_if / kti_out_if
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface kti_in_if;
    import kti_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      opcode;
    logic [ROW_W-1:0]     key_row;
    logic [ID_W-1:0]      track_id;
    logic signed [VAL_W-1:0] key_value;
    logic [BLEND_W-1:0]   blend_mode;
    logic [TIME_W-1:0]    query_time;

    modport source (output valid, opcode, key_row, track_id, key_value, blend_mode,
                    query_time, input ready);
    modport sink (input valid, opcode, key_row, track_id, key_value, blend_mode,
                  query_time, output ready);
endinterface

interface kti_out_if;
    import kti_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] result_value;
    logic [STAT_W-1:0]       status;
    logic                    finished;

    modport source (output valid, result_value, status, finished, input ready);
    modport sink (input valid, result_value, status, finished, output ready);
endinterface

// ===== src/keyframe_track_interpolator_core.sv =====
// ----------------------------------------------------------------------------
// keyframe_track_interpolator_core
// Keyframe store and evaluator: decode queue in front, sequencer behind it.
// ----------------------------------------------------------------------------
// Clear empties the store. Add shifts the later keys up one place, or writes directly
// into an empty store; index walks every key. Evaluate forms the row time with two
// multiplies and a 4-step reciprocal, walks the track's keys, and when blending runs
// the serial fraction divide, then the multiplies.
// Throughput is one item at a time, set by the serial divider and the key memory port.
// Reset clears key count, index and cursors; tempo 120, rows per beat 8.
// ----------------------------------------------------------------------------
module keyframe_track_interpolator_core #(
    parameter int MAX_KEYS = kti_pkg::MAX_KEYS_DEF,
    parameter int NUM_IDS  = kti_pkg::NUM_IDS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    kti_in_if.sink                        cmd,
    kti_out_if.source                     res,
    input  logic                          cfg_wr_en,
    input  logic [kti_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [kti_pkg::CFG_DAT_W-1:0] cfg_wdata
);
    import kti_pkg::*;

    logic [BPM_W-1:0] bpm_reg;
    logic [RPB_W-1:0] rpb_reg;
    cmd_t             q_head;
    logic             q_valid;
    logic             q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpm_reg <= BPM_RESET;
            rpb_reg <= RPB_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_BPM: bpm_reg <= cfg_wdata;
                CFG_RPB: rpb_reg <= cfg_wdata[RPB_W-1:0];
                default: bpm_reg <= bpm_reg;
            endcase
        end
    end

    kti_front #(
        .NUM_IDS (NUM_IDS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_head  (q_head),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    kti_back #(
        .MAX_KEYS (MAX_KEYS),
        .NUM_IDS  (NUM_IDS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_head  (q_head),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .bpm     (bpm_reg),
        .rpb     (rpb_reg),
        .res     (res)
    );

endmodule

// ===== src/kti_front.sv =====
// ----------------------------------------------------------------------------
// kti_front
// Takes command transfers, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module kti_front #(
    parameter int NUM_IDS = kti_pkg::NUM_IDS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    kti_in_if.sink        cmd,
    output kti_pkg::cmd_t q_head,
    output logic          q_valid,
    input  logic          q_pop
);
    import kti_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    logic       pop;
    cmd_t       incoming;

    assign cmd.ready = (fill_reg != 2'd2);
    assign push      = cmd.valid && cmd.ready;
    assign q_valid   = (fill_reg != 2'd0);
    assign pop       = q_pop && q_valid;
    assign q_head    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        incoming.op    = opcode_t'(cmd.opcode);
        incoming.row   = cmd.key_row;
        incoming.id    = cmd.track_id;
        incoming.id_ok = (32'(cmd.track_id) < NUM_IDS);
        incoming.value = cmd.key_value;
        incoming.blend = cmd.blend_mode;
        incoming.qtime = cmd.query_time;
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

// ===== src/kti_div.sv =====
// ----------------------------------------------------------------------------
// kti_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kti_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  kti_pkg::div_ctl_t            ctl,
    input  logic [kti_pkg::DIV_W-1:0]    dividend,
    input  logic [kti_pkg::DSR_W-1:0]    divisor,
    output logic [kti_pkg::DIV_W-1:0]    quotient,
    output logic                         done
);
    import kti_pkg::*;

    logic [DIV_W-1:0]     dvd_reg;
    logic [DSR_W-1:0]     rem_reg;
    logic [DSR_W-1:0]     dsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DSR_W:0]       shifted;
    logic                 ge;
    logic [DSR_W-1:0]     rem_next;

    always_comb
    begin
        shifted  = {rem_reg, dvd_reg[DIV_W-1]};
        ge       = (shifted >= {1'b0, dsr_reg});
        rem_next = ge ? DSR_W'(shifted - {1'b0, dsr_reg}) : DSR_W'(shifted);
    end

    assign quotient = dvd_reg;
    assign done     = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            dvd_reg  <= '0;
            rem_reg  <= '0;
            dsr_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                dvd_reg  <= dividend;
                dsr_reg  <= divisor;
                rem_reg  <= '0;
                cnt_reg  <= ctl.iters;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                dvd_reg <= {dvd_reg[DIV_W-2:0], ge};
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== src/kti_back.sv =====
// ----------------------------------------------------------------------------
// kti_back
// Key store, per-id index and evaluation sequencer with result register.
// ----------------------------------------------------------------------------
module kti_back #(
    parameter int MAX_KEYS = kti_pkg::MAX_KEYS_DEF,
    parameter int NUM_IDS  = kti_pkg::NUM_IDS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  kti_pkg::cmd_t             q_head,
    input  logic                      q_valid,
    output logic                      q_pop,
    input  logic [kti_pkg::BPM_W-1:0] bpm,
    input  logic [kti_pkg::RPB_W-1:0] rpb,
    kti_out_if.source                 res
);
    import kti_pkg::*;

    localparam int IDX_W    = $clog2(MAX_KEYS);
    localparam int CNT_W    = $clog2(MAX_KEYS + 1);
    localparam int ID_IDX_W = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_ADD, S_ADD_PUT, S_IDX,
        S_EV_MUL, S_EV_DIV, S_EV_DIVW, S_EV_CHECK, S_EV_WALK, S_EV_BLEND,
        S_EV_SPAN, S_EV_SPANW, S_EV_SQ, S_EV_SHAPE, S_EV_SCALE, S_EV_SUM, S_RESULT
    } state_t;

    state_t state_reg;
    cmd_t   cur_reg;

    // key memory
    key_t             key_mem [MAX_KEYS];
    key_t             rd_data_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    key_t             mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;

    logic [CNT_W-1:0] count_reg;
    logic [ROW_W-1:0] latest_reg;
    logic [CNT_W-1:0] ptr_reg;
    logic             first_step_reg;

    logic [IDX_W-1:0]   first_reg  [NUM_IDS];
    logic [IDX_W-1:0]   last_reg   [NUM_IDS];
    logic [IDX_W-1:0]   cursor_reg [NUM_IDS];
    logic [NUM_IDS-1:0] present_reg;
    logic [NUM_IDS-1:0] cset_reg;

    // evaluation datapath
    logic [PROD1_W-1:0]      prod1_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [RCP_W-1:0]        rcp_reg;
    logic [1:0]              rcp_step_reg;
    logic [RCP_W-1:0]        rcp_sum;
    logic [RT_W-1:0]         rt_reg;
    logic [ROW_W-1:0]        r0_reg;
    logic [ROW_W-1:0]        r1_reg;
    logic [VAL_W-1:0]        v0_reg;
    logic [VAL_W-1:0]        v1_reg;
    logic [BLEND_W-1:0]      b0_reg;
    logic [15:0]             a_reg;
    logic [15:0]             a2_reg;
    logic [16:0]             s_reg;
    logic signed [50:0]      scaled_reg;

    // result
    logic [VAL_W-1:0]  rv_reg;
    status_t           rs_reg;
    logic              rf_reg;
    logic              out_valid_reg;
    logic [VAL_W-1:0]  out_value_reg;
    status_t           out_status_reg;
    logic              out_fin_reg;

    // divider
    div_ctl_t          div_ctl;
    logic [DIV_W-1:0]  div_dividend;
    logic [DSR_W-1:0]  div_divisor;
    logic [DIV_W-1:0]  div_quot;
    logic              div_done;

    logic [ID_IDX_W-1:0] cur_idx;
    logic [ID_IDX_W-1:0] rd_idx;
    logic                rd_id_ok;
    logic [IDX_W-1:0]    start_idx;
    logic [34:0]         row_now;
    logic                rd_at_or_before;
    logic                shift_up;
    key_t                new_key;
    logic [31:0]         frac_num;
    logic [37:0]         latest_scaled;
    logic [33:0]         smooth_prod;
    logic signed [32:0]  vdiff;

    assign cur_idx  = ID_IDX_W'(cur_reg.id);
    assign rd_idx   = ID_IDX_W'(rd_data_reg.id);
    assign rd_id_ok = (32'(rd_data_reg.id) < NUM_IDS);
    assign start_idx = cset_reg[cur_idx] ? cursor_reg[cur_idx] : first_reg[cur_idx];
    assign row_now  = rt_reg[RT_W-1:16];
    assign rd_at_or_before = ({19'd0, rd_data_reg.row} <= row_now);
    assign shift_up = (rd_data_reg.id > cur_reg.id);
    assign new_key  = '{row: cur_reg.row, id: cur_reg.id, value: cur_reg.value,
                        blend: cur_reg.blend};
    assign frac_num = 32'(rt_reg - {19'd0, r0_reg, 16'd0});
    assign latest_scaled = {22'(latest_reg) * 22'd60, 16'd0};
    assign smooth_prod = a2_reg * (SMOOTH_K - {1'b0, a_reg, 1'b0});
    assign vdiff = $signed({v1_reg[VAL_W-1], v1_reg}) - $signed({v0_reg[VAL_W-1], v0_reg});

    assign q_pop = (state_reg == S_IDLE);

    assign res.valid        = out_valid_reg;
    assign res.result_value = out_value_reg;
    assign res.status       = out_status_reg;
    assign res.finished     = out_fin_reg;

    // (x+1) * 0x1111111111111111 built as x*0x11, *0x101, *0x10001, *0x100000001
    always_comb
    begin
        case (rcp_step_reg)
            2'd0:    rcp_sum = rcp_reg + (rcp_reg << 4);
            2'd1:    rcp_sum = rcp_reg + (rcp_reg << 8);
            2'd2:    rcp_sum = rcp_reg + (rcp_reg << 16);
            default: rcp_sum = rcp_reg + (rcp_reg << 32);
        endcase
    end

    always_comb
    begin
        div_ctl.start = (state_reg == S_EV_SPAN);
        div_ctl.iters = ITERS_FRAC;
        div_dividend  = {frac_num, 24'd0};
        div_divisor   = DSR_W'(r1_reg - r0_reg);
    end

    kti_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .done     (div_done)
    );

    // memory port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = new_key;
        mem_re    = 1'b0;
        mem_raddr = '0;
        case (state_reg)
            S_DISPATCH:
            begin
                if (cur_reg.op == OP_ADD && count_reg < CNT_W'(MAX_KEYS))
                begin
                    if (count_reg == '0)
                    begin
                        mem_we = 1'b1;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = IDX_W'(count_reg - 1'b1);
                    end
                end
                else if (cur_reg.op == OP_INDEX && count_reg != '0)
                begin
                    mem_re = 1'b1;
                end
            end
            S_ADD:
            begin
                mem_we    = 1'b1;
                mem_waddr = IDX_W'(ptr_reg);
                if (shift_up)
                begin
                    mem_wdata = rd_data_reg;
                    if (ptr_reg != CNT_W'(1))
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = IDX_W'(ptr_reg - CNT_W'(2));
                    end
                end
            end
            S_ADD_PUT:
            begin
                mem_we = 1'b1;
            end
            S_IDX:
            begin
                if (ptr_reg + 1'b1 != count_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = IDX_W'(ptr_reg + 1'b1);
                end
            end
            S_EV_CHECK:
            begin
                mem_re    = 1'b1;
                mem_raddr = start_idx;
            end
            S_EV_WALK:
            begin
                if (rd_at_or_before && ptr_reg != CNT_W'(last_reg[cur_idx]))
                begin
                    mem_re    = 1'b1;
                    mem_raddr = IDX_W'(ptr_reg + 1'b1);
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= key_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_reg        <= '0;
            count_reg      <= '0;
            latest_reg     <= '0;
            ptr_reg        <= '0;
            first_step_reg <= 1'b0;
            present_reg    <= '0;
            cset_reg       <= '0;
            for (int i = 0; i < NUM_IDS; i++)
            begin
                first_reg[i]  <= '0;
                last_reg[i]   <= '0;
                cursor_reg[i] <= '0;
            end
            prod1_reg      <= '0;
            prod_reg       <= '0;
            rcp_reg        <= '0;
            rcp_step_reg   <= '0;
            rt_reg         <= '0;
            r0_reg         <= '0;
            r1_reg         <= '0;
            v0_reg         <= '0;
            v1_reg         <= '0;
            b0_reg         <= '0;
            a_reg          <= '0;
            a2_reg         <= '0;
            s_reg          <= '0;
            scaled_reg     <= '0;
            rv_reg         <= '0;
            rs_reg         <= ST_DONE;
            rf_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_status_reg <= ST_DONE;
            out_fin_reg    <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && res.ready && state_reg != S_RESULT)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cur_reg   <= q_head;
                        state_reg <= S_DISPATCH;
                    end
                end

                S_DISPATCH:
                begin
                    rv_reg <= '0;
                    rf_reg <= 1'b0;
                    rs_reg <= ST_DONE;
                    case (cur_reg.op)
                        OP_CLEAR:
                        begin
                            count_reg   <= '0;
                            latest_reg  <= '0;
                            present_reg <= '0;
                            cset_reg    <= '0;
                            state_reg   <= S_RESULT;
                        end
                        OP_ADD:
                        begin
                            if (count_reg >= CNT_W'(MAX_KEYS))
                            begin
                                rs_reg    <= ST_FULL;
                                state_reg <= S_RESULT;
                            end
                            else if (count_reg == '0)
                            begin
                                count_reg  <= CNT_W'(1);
                                latest_reg <= cur_reg.row;
                                state_reg  <= S_RESULT;
                            end
                            else
                            begin
                                ptr_reg   <= count_reg;
                                state_reg <= S_ADD;
                            end
                        end
                        OP_INDEX:
                        begin
                            present_reg <= '0;
                            cset_reg    <= '0;
                            ptr_reg     <= '0;
                            state_reg   <= (count_reg == '0) ? S_RESULT : S_IDX;
                        end
                        OP_EVAL:
                        begin
                            prod1_reg <= cur_reg.qtime * rpb;
                            state_reg <= S_EV_MUL;
                        end
                        default:
                        begin
                            state_reg <= S_RESULT;
                        end
                    endcase
                end

                S_ADD:
                begin
                    if (shift_up)
                    begin
                        ptr_reg <= ptr_reg - 1'b1;
                        if (ptr_reg == CNT_W'(1))
                        begin
                            state_reg <= S_ADD_PUT;
                        end
                    end
                    else
                    begin
                        count_reg <= count_reg + 1'b1;
                        if (latest_reg < cur_reg.row)
                        begin
                            latest_reg <= cur_reg.row;
                        end
                        state_reg <= S_RESULT;
                    end
                end

                S_ADD_PUT:
                begin
                    count_reg <= count_reg + 1'b1;
                    if (latest_reg < cur_reg.row)
                    begin
                        latest_reg <= cur_reg.row;
                    end
                    state_reg <= S_RESULT;
                end

                S_IDX:
                begin
                    if (rd_id_ok)
                    begin
                        if (!present_reg[rd_idx])
                        begin
                            present_reg[rd_idx] <= 1'b1;
                            first_reg[rd_idx]   <= IDX_W'(ptr_reg);
                        end
                        last_reg[rd_idx] <= IDX_W'(ptr_reg);
                    end
                    ptr_reg <= ptr_reg + 1'b1;
                    if (ptr_reg + 1'b1 == count_reg)
                    begin
                        state_reg <= S_RESULT;
                    end
                end

                S_EV_MUL:
                begin
                    prod_reg  <= prod1_reg * bpm;
                    state_reg <= S_EV_DIV;
                end

                S_EV_DIV:
                begin
                    rf_reg       <= ({18'd0, latest_scaled} < prod_reg) || (count_reg == '0);
                    // floor(P/60) = floor(((P >> 2) + 1) * 0x1111111111111111 / 2^64)
                    rcp_reg      <= RCP_W'(prod_reg[PROD_W-1:2]) + RCP_W'(1);
                    rcp_step_reg <= '0;
                    state_reg    <= S_EV_DIVW;
                end

                S_EV_DIVW:
                begin
                    rcp_reg      <= rcp_sum;
                    rcp_step_reg <= rcp_step_reg + 2'd1;
                    if (rcp_step_reg == 2'd3)
                    begin
                        rt_reg    <= rcp_sum[RCP_SHIFT +: RT_W];
                        state_reg <= S_EV_CHECK;
                    end
                end

                S_EV_CHECK:
                begin
                    if (cur_reg.id_ok && present_reg[cur_idx])
                    begin
                        ptr_reg        <= CNT_W'(start_idx);
                        first_step_reg <= 1'b1;
                        state_reg      <= S_EV_WALK;
                    end
                    else
                    begin
                        rs_reg    <= ST_INACTIVE;
                        state_reg <= S_RESULT;
                    end
                end

                S_EV_WALK:
                begin
                    if (rd_at_or_before)
                    begin
                        r0_reg              <= rd_data_reg.row;
                        v0_reg              <= rd_data_reg.value;
                        b0_reg              <= rd_data_reg.blend;
                        cursor_reg[cur_idx] <= IDX_W'(ptr_reg);
                        cset_reg[cur_idx]   <= 1'b1;
                        first_step_reg      <= 1'b0;
                        if (ptr_reg == CNT_W'(last_reg[cur_idx]))
                        begin
                            // no later key: hold this key's value
                            rv_reg    <= rd_data_reg.value;
                            rs_reg    <= ST_VALID;
                            state_reg <= S_RESULT;
                        end
                        else
                        begin
                            ptr_reg <= ptr_reg + 1'b1;
                        end
                    end
                    else if (first_step_reg)
                    begin
                        rs_reg    <= ST_INACTIVE;
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        r1_reg    <= rd_data_reg.row;
                        v1_reg    <= rd_data_reg.value;
                        state_reg <= S_EV_BLEND;
                    end
                end

                S_EV_BLEND:
                begin
                    if (b0_reg == BL_STEP)
                    begin
                        rv_reg    <= v0_reg;
                        rs_reg    <= ST_VALID;
                        state_reg <= S_RESULT;
                    end
                    else if (b0_reg > BL_RAMP)
                    begin
                        rs_reg    <= ST_BAD_BLEND;
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        state_reg <= S_EV_SPAN;
                    end
                end

                S_EV_SPAN:
                begin
                    state_reg <= S_EV_SPANW;
                end

                S_EV_SPANW:
                begin
                    if (div_done)
                    begin
                        a_reg     <= (div_quot[31:16] != 16'd0) ? 16'hFFFF : div_quot[15:0];
                        state_reg <= S_EV_SQ;
                    end
                end

                S_EV_SQ:
                begin
                    a2_reg    <= 16'((32'(a_reg) * 32'(a_reg)) >> 16);
                    state_reg <= S_EV_SHAPE;
                end

                S_EV_SHAPE:
                begin
                    case (b0_reg)
                        BL_SMOOTH: s_reg <= smooth_prod[32:16];
                        BL_RAMP:   s_reg <= {1'b0, a2_reg};
                        default:   s_reg <= {1'b0, a_reg};
                    endcase
                    state_reg <= S_EV_SCALE;
                end

                S_EV_SCALE:
                begin
                    scaled_reg <= 51'(vdiff) * 51'($signed({1'b0, s_reg}));
                    state_reg  <= S_EV_SUM;
                end

                S_EV_SUM:
                begin
                    // arithmetic shift gives the floor toward minus infinity
                    rv_reg    <= v0_reg + VAL_W'(scaled_reg >>> 16);
                    rs_reg    <= ST_VALID;
                    state_reg <= S_RESULT;
                end

                S_RESULT:
                begin
                    if (!out_valid_reg || res.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_value_reg  <= rv_reg;
                        out_status_reg <= rs_reg;
                        out_fin_reg    <= rf_reg;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for keyframe_track_interpolator_core. Commands are driven
// on the input channel with random gaps; an in-bench scoreboard keeps its own
// keyframe store, per-id index and cursors, predicts every result and compares
// it field by field as the result transfer arrives.
// ----------------------------------------------------------------------------
module tb;
    import kti_pkg::*;

    localparam int  LIMIT_CYCLES = 6_000_000;
    localparam int  KEY_SLOTS    = MAX_KEYS_DEF;
    localparam int  TRACKS       = NUM_IDS_DEF;

    typedef struct {
        opcode_t               op;
        logic [ROW_W-1:0]      row;
        logic [ID_W-1:0]       id;
        logic [VAL_W-1:0]      value;
        logic [BLEND_W-1:0]    blend;
        logic [TIME_W-1:0]     qtime;
    } track_cmd_t;

    typedef struct {
        logic [VAL_W-1:0]      value;
        status_t               status;
        logic                  finished;
    } track_res_t;

    typedef struct {
        logic [ROW_W-1:0]      row;
        logic [ID_W-1:0]       id;
        logic [VAL_W-1:0]      value;
        logic [BLEND_W-1:0]    blend;
    } keyframe_t;

    // ------------------------------------------------------------------------
    class track_scoreboard;
        keyframe_t      keys[KEY_SLOTS];
        int unsigned    key_total;
        int unsigned    top_row;
        int unsigned    first_pos[TRACKS];
        int unsigned    last_pos[TRACKS];
        bit             listed[TRACKS];
        int unsigned    cursor[TRACKS];
        bit             cursor_ok[TRACKS];
        longint unsigned bpm;
        longint unsigned rpb;
        track_res_t     pending[$];
        int             errors;

        function new();
            key_total = 0;
            top_row   = 0;
            bpm       = 120;
            rpb       = 8;
            errors    = 0;
            drop_index();
        endfunction

        function void drop_index();
            for (int k = 0; k < TRACKS; k++)
            begin
                listed[k]    = 0;
                cursor_ok[k] = 0;
                first_pos[k] = 0;
                last_pos[k]  = 0;
                cursor[k]    = 0;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            if (idx == CFG_BPM)
                bpm = data;
            else
                rpb = data[RPB_W-1:0];
        endfunction

        function track_res_t evaluate(logic [ID_W-1:0] id, logic [TIME_W-1:0] qt);
            track_res_t      r;
            longint unsigned prod, rt, row, r0, span, a, s, a2;
            longint          v0, v1, p;
            int unsigned     start, e0, e1;
            bit              later;
            r.value    = '0;
            r.status   = ST_INACTIVE;
            prod       = longint'(qt) * rpb * bpm;
            rt         = prod / 60;
            row        = rt >> 16;
            r.finished = ((longint'(top_row) << 16) * 60 < prod) || key_total == 0;
            if (!listed[id])
                return r;
            start = cursor_ok[id] ? cursor[id] : first_pos[id];
            if (keys[start].row > row)
                return r;
            e0    = start;
            e1    = 0;
            later = 0;
            for (int unsigned i = start; i <= last_pos[id]; i++)
            begin
                if (keys[i].row <= row)
                begin
                    e0            = i;
                    cursor[id]    = i;
                    cursor_ok[id] = 1;
                end
                else
                begin
                    e1    = i;
                    later = 1;
                    break;
                end
            end
            v0 = longint'($signed(keys[e0].value));
            if (!later || keys[e0].blend == BL_STEP)
            begin
                r.value  = keys[e0].value;
                r.status = ST_VALID;
            end
            else if (keys[e0].blend > BL_RAMP)
                r.status = ST_BAD_BLEND;
            else
            begin
                r0   = keys[e0].row;
                span = longint'(keys[e1].row) - r0;
                a    = (rt - (r0 << 16)) / span;
                if (a > 65535)
                    a = 65535;
                s = a;
                if (keys[e0].blend == BL_SMOOTH)
                begin
                    a2 = (a * a) >> 16;
                    s  = (a2 * (196608 - 2 * a)) >> 16;
                end
                else if (keys[e0].blend == BL_RAMP)
                    s = (a * a) >> 16;
                v1       = longint'($signed(keys[e1].value));
                p        = (v1 - v0) * longint'(s);
                r.value  = VAL_W'(v0 + (p >>> 16));
                r.status = ST_VALID;
            end
            return r;
        endfunction

        // an input transfer was accepted: update the store and queue the answer
        function void note_command(track_cmd_t c);
            track_res_t r;
            int unsigned pos;
            r.value    = '0;
            r.status   = ST_DONE;
            r.finished = 0;
            case (c.op)
                OP_CLEAR:
                begin
                    key_total = 0;
                    top_row   = 0;
                    drop_index();
                end
                OP_ADD:
                begin
                    if (key_total >= KEY_SLOTS)
                        r.status = ST_FULL;
                    else
                    begin
                        pos = 0;
                        while (pos < key_total && keys[pos].id <= c.id)
                            pos++;
                        for (int unsigned i = key_total; i > pos; i--)
                            keys[i] = keys[i-1];
                        keys[pos].row   = c.row;
                        keys[pos].id    = c.id;
                        keys[pos].value = c.value;
                        keys[pos].blend = c.blend;
                        key_total++;
                        if (top_row < c.row)
                            top_row = c.row;
                    end
                end
                OP_INDEX:
                begin
                    drop_index();
                    for (int unsigned i = 0; i < key_total; i++)
                    begin
                        if (!listed[keys[i].id])
                        begin
                            listed[keys[i].id]    = 1;
                            first_pos[keys[i].id] = i;
                        end
                        last_pos[keys[i].id] = i;
                    end
                end
                default:
                    r = evaluate(c.id, c.qtime);
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(track_res_t got);
            track_res_t want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result value %h status %0d finished %0b",
                         $time, got.value, got.status, got.finished);
                return;
            end
            want = pending.pop_front();
            if (got.value !== want.value)
            begin
                errors++;
                $display("%0t: result_value expected %h actual %h", $time, want.value,
                         got.value);
            end
            if (got.status !== want.status)
            begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, want.status,
                         got.status);
            end
            if (got.finished !== want.finished)
            begin
                errors++;
                $display("%0t: finished expected %0b actual %0b", $time, want.finished,
                         got.finished);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_DAT_W-1:0] cfg_wdata;

    kti_in_if  cmd_if ();
    kti_out_if res_if ();

    keyframe_track_interpolator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_if),
        .res       (res_if),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    track_scoreboard board = new();
    int  sent;
    bit  tx_gaps;
    bit  hold_req;
    longint cycles;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: random stalls, quiet stretches, and one long hold-off
    initial
    begin
        int         wait_n;
        bit         rx_gaps;
        int         since;
        track_res_t got;
        res_if.ready = 1'b0;
        rx_gaps = 1;
        since   = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                res_if.ready <= 1'b0;
                repeat (600) @(posedge clk);
                hold_req = 0;
            end
            else
            begin
                wait_n = rx_gaps ? $urandom_range(0, 19) : 0;
                if (wait_n > 0)
                begin
                    res_if.ready <= 1'b0;
                    repeat (wait_n) @(posedge clk);
                end
            end
            res_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(res_if.valid && res_if.ready));
            got.value    = res_if.result_value;
            got.status   = status_t'(res_if.status);
            got.finished = res_if.finished;
            board.check_result(got);
            if (++since > 150)
            begin
                since   = 0;
                rx_gaps = $urandom_range(0, 3) != 0;
            end
        end
    end

    task automatic send(opcode_t op, int unsigned row, int unsigned id,
                        logic [VAL_W-1:0] value, int unsigned blend,
                        logic [TIME_W-1:0] qtime);
        track_cmd_t c;
        int         gap;
        c.op    = op;
        c.row   = ROW_W'(row);
        c.id    = ID_W'(id);
        c.value = value;
        c.blend = BLEND_W'(blend);
        c.qtime = qtime;
        gap = tx_gaps ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.opcode     <= c.op;
        cmd_if.key_row    <= c.row;
        cmd_if.track_id   <= c.id;
        cmd_if.key_value  <= c.value;
        cmd_if.blend_mode <= c.blend;
        cmd_if.query_time <= c.qtime;
        cmd_if.valid      <= 1'b1;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        board.note_command(c);
        sent++;
    endtask

    // wait until every result is in, with the input side quiet
    task automatic drain();
        cmd_if.valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_tempo(int unsigned bpm, int unsigned rpb);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_BPM;
        cfg_wdata <= CFG_DAT_W'(bpm);
        @(posedge clk);
        board.set_reg(CFG_BPM, CFG_DAT_W'(bpm));
        cfg_addr  <= CFG_RPB;
        cfg_wdata <= CFG_DAT_W'(rpb);
        @(posedge clk);
        board.set_reg(CFG_RPB, CFG_DAT_W'(rpb));
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // seconds (Q16.16) that reach the given row time (Q16.16 rows)
    function automatic logic [TIME_W-1:0] time_at(longint unsigned rows_q);
        longint unsigned t;
        t = rows_q * 60 / (board.bpm * board.rpb);
        return (t > 64'hFFFF_FFFF) ? '1 : TIME_W'(t);
    endfunction

    function automatic int unsigned any_blend();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
    endfunction

    task automatic track_phase(bit fill);
        int unsigned ids[4];
        int unsigned n_keys, n_evals, span_rows;
        longint unsigned t_rows;
        if ($urandom_range(0, 5) != 0)
            send(OP_CLEAR, 0, 0, '0, 0, '0);
        foreach (ids[k])
            ids[k] = $urandom_range(0, 31);
        span_rows = ($urandom_range(0, 7) == 0) ? 65535 : 300;
        n_keys = fill ? 262 : $urandom_range(1, 24);
        for (int k = 0; k < n_keys; k++)
            send(OP_ADD, $urandom_range(0, span_rows), ids[$urandom_range(0, 3)],
                 $urandom(), any_blend(), $urandom());
        if ($urandom_range(0, 7) != 0)
            send(OP_INDEX, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        if ($urandom_range(0, 5) == 0)
            send(OP_ADD, $urandom_range(0, span_rows), ids[0], $urandom(), any_blend(),
                 $urandom());
        n_evals = $urandom_range(4, 30);
        t_rows  = 0;
        for (int k = 0; k < n_evals; k++)
        begin
            case ($urandom_range(0, 9))
                0:       send(OP_EVAL, $urandom(), $urandom(), $urandom(), $urandom(),
                              $urandom());
                1:       send(OP_EVAL, $urandom(), ids[$urandom_range(0, 3)], $urandom(),
                              $urandom(), time_at(longint'($urandom_range(0, span_rows))
                                                  << 16));
                default:
                begin
                    // mostly forward in time so the cursors walk
                    t_rows += $urandom_range(0,
                                  32'((longint'(span_rows) + 1) * 65536 / 8));
                    send(OP_EVAL, $urandom(), ids[$urandom_range(0, 3)], $urandom(),
                         $urandom(), time_at(t_rows));
                end
            endcase
        end
        // a little noise
        repeat ($urandom_range(0, 2))
            send(opcode_t'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom(),
                 $urandom(), $urandom());
    endtask

    initial
    begin
        int tempo_bpm[5] = '{120, 1, 65535, 1, 65535};
        int tempo_rpb[5] = '{8, 1, 255, 255, 1};
        int pick;
        rst_n        = 1'b0;
        cycles       = 0;
        sent         = 0;
        hold_req     = 0;
        tx_gaps      = 1;
        cfg_wr_en    = 1'b0;
        cfg_addr     = CFG_BPM;
        cfg_wdata    = '0;
        cmd_if.valid      = 1'b0;
        cmd_if.opcode     = OP_CLEAR;
        cmd_if.key_row    = '0;
        cmd_if.track_id   = '0;
        cmd_if.key_value  = '0;
        cmd_if.blend_mode = '0;
        cmd_if.query_time = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty store, every blend, unknown blend, cursor and edge cases
        send(OP_EVAL, 0, 0, '0, 0, '0);
        send(OP_CLEAR, 0, 0, '0, 0, '0);
        send(OP_ADD, 0, 0, 32'h8000_0000, BL_LINEAR, '0);
        send(OP_ADD, 10, 0, 32'h7FFF_FFFF, BL_SMOOTH, '0);
        send(OP_ADD, 20, 0, 32'h0001_0000, BL_RAMP, '0);
        send(OP_ADD, 30, 0, 32'hFFFF_0000, 5, '0);
        send(OP_ADD, 40, 0, 32'h1234_5678, BL_STEP, '0);
        send(OP_ADD, 65535, 31, 32'hFFFF_FFFF, 7, 32'hFFFF_FFFF);
        send(OP_ADD, 50, 0, 32'h0000_0000, BL_LINEAR, '0);
        send(OP_INDEX, 0, 0, '0, 0, '0);
        send(OP_EVAL, 0, 0, '0, 0, time_at(64'h4_8000));
        send(OP_EVAL, 0, 0, '0, 0, time_at(64'hE_C000));
        send(OP_EVAL, 0, 0, '0, 0, time_at(64'h19_4000));
        send(OP_EVAL, 0, 0, '0, 0, time_at(64'h20_0000));
        send(OP_EVAL, 0, 0, '0, 0, time_at(64'h29_0000));
        send(OP_EVAL, 0, 0, '0, 0, time_at(64'h4_0000));  // cursor already past
        send(OP_EVAL, 0, 0, '0, 0, time_at(64'h40_0000));
        send(OP_EVAL, 0, 7, '0, 0, time_at(64'h40_0000));  // id absent
        send(OP_EVAL, 0, 31, '0, 0, time_at(64'h40_0000)); // key still ahead
        send(OP_ADD, 5, 3, 32'h0000_1000, BL_LINEAR, '0);  // not indexed yet
        send(OP_EVAL, 0, 3, '0, 0, time_at(64'h40_0000));
        send(OP_EVAL, 0, 31, '0, 0, 32'hFFFF_FFFF);

        for (int phase = 0; sent < 1600; phase++)
        begin
            if (phase % 6 == 0)
            begin
                pick = (phase / 6) % 7;
                if (pick < 5)
                    set_tempo(tempo_bpm[pick], tempo_rpb[pick]);
                else
                    set_tempo($urandom_range(1, 65535), $urandom_range(1, 255));
            end
            tx_gaps = $urandom_range(0, 3) != 0;
            if (phase == 5)
            begin
                // receiver holds off while the sender keeps offering
                hold_req = 1;
                tx_gaps  = 0;
            end
            if (phase == 9)
                drain();
            track_phase(phase == 14);
        end

        drain();
        repeat (400) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
